[sv/ipss_pkg.sv]
package ipss_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int NUM_COLORS     = 256;
    localparam int COLOR_W        = 8;
    localparam int HADDR_W        = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_SHADOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW_COLOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DITHERED     = 3'd4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic [3:0] {
        NB_C,
        NB_L1,
        NB_L2,
        NB_R1,
        NB_R2,
        NB_U1,
        NB_U2,
        NB_D1,
        NB_D2,
        NB_X
    } t_nb;

    typedef struct packed {
        logic load_wr;
        logic latch;
        logic fetch_rd;
        logic out_load;
        logic img_rd;
        t_nb  nb;
        logic k_clr;
        logic sweep_clr;
        logic hist_inc;
        logic arg_rd;
        logic pick;
        logic pos_clr;
        logic sep_wr;
        logic dmask_wr;
        logic next_wr;
        logic adv;
        logic skip;
    } t_cmd;

    typedef struct packed {
        logic load_done;
        logic sweep_done;
        logic arg_done;
        logic last1;
        logic last2;
        logic hist_hit;
        logic shadow_hit;
        logic right_mark;
        logic dmark;
        logic last_read;
        logic dith;
        logic auto_on;
        logic clash;
        logic out_free;
    } t_sts;

endpackage

[sv/ipss_ram.sv]
module ipss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ipss_datapath.sv]
module ipss_datapath #(
    parameter int MAX_WIDTH  = ipss_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ipss_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ipss_pkg::t_cmd                   i_cmd,
    output ipss_pkg::t_sts                   o_sts,
    input  logic                             i_cfg_we,
    input  logic [ipss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ipss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [ipss_pkg::COLOR_W-1:0]     i_pixel_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ipss_pkg::COLOR_W-1:0]     o_pixel_out,
    output logic                             o_is_shadow,
    output logic                             o_last,
    output logic                             o_index_clash,
    output logic [ipss_pkg::COLOR_W-1:0]     o_shadow_index_used
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PW          = CNT_W + 1;
    localparam int DIM_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
    localparam int EXTW_W      = (DIM_W > 8) ? DIM_W : 8;
    localparam int EXTH_W      = (ROW_W > 8) ? ROW_W : 8;
    localparam int PROD_W      = DIM_W + ROW_W;
    localparam int SWP_W       = (CNT_W > 9) ? CNT_W : 9;
    localparam int HIST_W      = CNT_W;
    localparam int CW          = ipss_pkg::COLOR_W;
    localparam int HW          = ipss_pkg::HADDR_W;

    logic [7:0]    r_cfg_w;
    logic [7:0]    r_cfg_h;
    logic          r_cfg_auto;
    logic [CW-1:0] r_cfg_shadow;
    logic          r_cfg_dith;

    logic [CNT_W-1:0] r_load_cnt;
    logic [CNT_W-1:0] r_read_cnt;
    logic [DIM_W-1:0] r_lw;
    logic [ROW_W-1:0] r_lh;
    logic [CNT_W-1:0] r_total;
    logic             r_dith;
    logic             r_auto;
    logic [CW-1:0]    r_scfg;
    logic [CW-1:0]    r_x;
    logic [CW-1:0]    r_s;
    logic             r_clash;
    logic [DIM_W-1:0] r_i;
    logic [ROW_W-1:0] r_j;
    logic [CNT_W-1:0] r_p;
    logic [SWP_W-1:0] r_k;

    logic [CW-1:0] r_vc, r_vl1, r_vl2, r_vr1, r_vr2, r_vu1, r_vu2, r_vd1, r_vd2;
    logic          r_cap_v;
    ipss_pkg::t_nb r_cap_sel;
    logic          r_arg_v;
    logic [HW-1:0] r_arg_idx;
    logic [HW-1:0] r_best;
    logic [HIST_W-1:0] r_best_cnt;

    logic          r_out_valid;
    logic [CW-1:0] r_out_pixel;
    logic          r_out_shadow;
    logic          r_out_last;
    logic          r_out_clash;
    logic [CW-1:0] r_out_used;

    logic [EXTW_W-1:0] w_ext;
    logic [EXTH_W-1:0] h_ext;
    logic [DIM_W-1:0]  w_cl;
    logic [ROW_W-1:0]  h_cl;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  total_cfg;

    logic [DIM_W:0] ie, we_d;
    logic [ROW_W:0] je, he;
    logic e_l1, e_l2, e_r1, e_r2, e_u1, e_u2, e_d1, e_d2;
    logic [PW-1:0] pe, wp;
    logic [PW-1:0] nb_addr;
    logic [DIM_W:0] i_next;
    logic           wrap;
    logic           iso, pair;
    logic [SWP_W:0] k_next;

    logic              img_we;
    logic [ADDR_W-1:0] img_waddr, img_raddr;
    logic [CW-1:0]     img_wdata, img_rdata;
    logic              msk_we;
    logic [ADDR_W-1:0] msk_waddr;
    logic              msk_wdata, msk_rdata;
    logic              hst_we;
    logic [HW-1:0]     hst_waddr, hst_raddr;
    logic [HIST_W-1:0] hst_wdata, hst_rdata;

    logic k_in_mask, k_in_hist, read_is_last;

    assign w_ext = EXTW_W'(r_cfg_w);
    assign h_ext = EXTH_W'(r_cfg_h);

    always_comb begin
        if (r_cfg_w == 8'd0) begin
            w_cl = DIM_W'(1);
        end else if (w_ext > EXTW_W'(MAX_WIDTH)) begin
            w_cl = DIM_W'(MAX_WIDTH);
        end else begin
            w_cl = DIM_W'(w_ext);
        end
        if (r_cfg_h == 8'd0) begin
            h_cl = ROW_W'(1);
        end else if (h_ext > EXTH_W'(MAX_HEIGHT)) begin
            h_cl = ROW_W'(MAX_HEIGHT);
        end else begin
            h_cl = ROW_W'(h_ext);
        end
    end

    assign prod      = PROD_W'(w_cl) * PROD_W'(h_cl);
    assign total_cfg = CNT_W'(prod);

    assign ie   = (DIM_W+1)'(r_i);
    assign we_d = (DIM_W+1)'(r_lw);
    assign je   = (ROW_W+1)'(r_j);
    assign he   = (ROW_W+1)'(r_lh);
    assign e_l1 = r_i != '0;
    assign e_l2 = ie > (DIM_W+1)'(1);
    assign e_r1 = (ie + (DIM_W+1)'(1)) < we_d;
    assign e_r2 = (ie + (DIM_W+1)'(2)) < we_d;
    assign e_u1 = r_j != '0;
    assign e_u2 = je > (ROW_W+1)'(1);
    assign e_d1 = (je + (ROW_W+1)'(1)) < he;
    assign e_d2 = (je + (ROW_W+1)'(2)) < he;

    assign pe = PW'(r_p);
    assign wp = PW'(r_lw);

    always_comb begin
        case (i_cmd.nb)
            ipss_pkg::NB_L1: nb_addr = e_l1 ? pe - PW'(1) : pe;
            ipss_pkg::NB_L2: nb_addr = e_l2 ? pe - PW'(2) : pe;
            ipss_pkg::NB_R1: nb_addr = e_r1 ? pe + PW'(1) : pe;
            ipss_pkg::NB_R2: nb_addr = e_r2 ? pe + PW'(2) : pe;
            ipss_pkg::NB_U1: nb_addr = e_u1 ? pe - wp : pe;
            ipss_pkg::NB_U2: nb_addr = e_u2 ? pe - (wp << 1) : pe;
            ipss_pkg::NB_D1: nb_addr = e_d1 ? pe + wp : pe;
            ipss_pkg::NB_D2: nb_addr = e_d2 ? pe + (wp << 1) : pe;
            ipss_pkg::NB_X:  nb_addr = '0;
            default:         nb_addr = pe;
        endcase
    end

    assign iso = (!e_l1 || r_vl1 == r_x) && (!e_r1 || r_vr1 == r_x)
              && (!e_u1 || r_vu1 == r_x) && (!e_d1 || r_vd1 == r_x);
    assign pair = (e_l2 && r_vl1 == r_x && r_vl2 == r_s)
               || (e_r2 && r_vr1 == r_x && r_vr2 == r_s)
               || (e_u2 && r_vu1 == r_x && r_vu2 == r_s)
               || (e_d2 && r_vd1 == r_x && r_vd2 == r_s);

    assign i_next = ie + (i_cmd.skip ? (DIM_W+1)'(2) : (DIM_W+1)'(1));
    assign wrap   = i_next >= we_d;
    assign k_next = (SWP_W+1)'(r_k) + (SWP_W+1)'(1);

    assign k_in_mask    = (SWP_W+1)'(r_k) < (SWP_W+1)'(r_total);
    assign k_in_hist    = (SWP_W+1)'(r_k) < (SWP_W+1)'(ipss_pkg::NUM_COLORS);
    assign read_is_last = (r_read_cnt + CNT_W'(1)) == r_total;

    always_comb begin
        o_sts            = '0;
        o_sts.load_done  = (PW'(r_load_cnt) + PW'(1)) >= PW'(total_cfg);
        o_sts.sweep_done = (k_next >= (SWP_W+1)'(r_total))
                        && (k_next >= (SWP_W+1)'(ipss_pkg::NUM_COLORS));
        o_sts.arg_done   = r_k == SWP_W'(ipss_pkg::NUM_COLORS - 1);
        o_sts.last1      = ((ie + (DIM_W+1)'(1)) >= we_d)
                        && ((je + (ROW_W+1)'(1)) >= he);
        o_sts.last2      = ((ie + (DIM_W+1)'(2)) >= we_d)
                        && ((je + (ROW_W+1)'(1)) >= he);
        o_sts.hist_hit   = (r_vc != r_x) && iso;
        o_sts.shadow_hit = (r_vc == r_s) && (!r_dith || pair || iso);
        o_sts.right_mark = e_r2 && r_vr1 == r_x && r_vr2 != r_x;
        o_sts.dmark      = (r_vc == r_x) && r_dith
                        && (!e_u1 || r_vu1 == r_s) && (!e_d1 || r_vd1 == r_s);
        o_sts.last_read  = read_is_last;
        o_sts.dith       = r_dith;
        o_sts.auto_on    = r_auto;
        o_sts.clash      = r_clash;
        o_sts.out_free   = !r_out_valid || i_ready;
    end

    always_comb begin
        img_we    = 1'b0;
        img_waddr = r_p[ADDR_W-1:0];
        img_wdata = r_x;
        if (i_cmd.load_wr) begin
            img_we    = 1'b1;
            img_waddr = r_load_cnt[ADDR_W-1:0];
            img_wdata = i_pixel_in;
        end else if (i_cmd.sep_wr) begin
            img_we = 1'b1;
        end
        img_raddr = i_cmd.fetch_rd ? r_read_cnt[ADDR_W-1:0] : nb_addr[ADDR_W-1:0];

        msk_we    = 1'b0;
        msk_waddr = r_p[ADDR_W-1:0];
        msk_wdata = 1'b1;
        if (i_cmd.sweep_clr) begin
            msk_we    = k_in_mask;
            msk_waddr = r_k[ADDR_W-1:0];
            msk_wdata = 1'b0;
        end else if (i_cmd.sep_wr || i_cmd.dmask_wr) begin
            msk_we = 1'b1;
        end else if (i_cmd.next_wr) begin
            msk_we    = 1'b1;
            msk_waddr = r_p[ADDR_W-1:0] + ADDR_W'(1);
        end

        hst_we    = 1'b0;
        hst_waddr = r_vc;
        hst_wdata = hst_rdata + HIST_W'(1);
        if (i_cmd.sweep_clr) begin
            hst_we    = k_in_hist;
            hst_waddr = r_k[HW-1:0];
            hst_wdata = '0;
        end else if (i_cmd.hist_inc) begin
            hst_we = 1'b1;
        end
        hst_raddr = i_cmd.arg_rd ? r_k[HW-1:0] : r_vc;
    end

    ipss_ram #(.WIDTH(CW), .DEPTH(STORE_DEPTH)) u_image (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (img_waddr),
        .i_wdata (img_wdata),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    ipss_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_mask (
        .i_clk   (i_clk),
        .i_we    (msk_we),
        .i_waddr (msk_waddr),
        .i_wdata (msk_wdata),
        .i_raddr (r_read_cnt[ADDR_W-1:0]),
        .o_rdata (msk_rdata)
    );

    ipss_ram #(.WIDTH(HIST_W), .DEPTH(ipss_pkg::NUM_COLORS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hst_we),
        .i_waddr (hst_waddr),
        .i_wdata (hst_wdata),
        .i_raddr (hst_raddr),
        .o_rdata (hst_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w      <= 8'd128;
            r_cfg_h      <= 8'd128;
            r_cfg_auto   <= 1'b1;
            r_cfg_shadow <= '0;
            r_cfg_dith   <= 1'b0;
            r_load_cnt   <= '0;
            r_read_cnt   <= '0;
            r_cap_v      <= 1'b0;
            r_arg_v      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ipss_pkg::REG_IMAGE_WIDTH:  r_cfg_w      <= i_cfg_data;
                    ipss_pkg::REG_IMAGE_HEIGHT: r_cfg_h      <= i_cfg_data;
                    ipss_pkg::REG_AUTO_SHADOW:  r_cfg_auto   <= i_cfg_data[0];
                    ipss_pkg::REG_SHADOW_COLOR: r_cfg_shadow <= i_cfg_data;
                    ipss_pkg::REG_DITHERED:     r_cfg_dith   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.load_wr) begin
                r_load_cnt <= r_load_cnt + CNT_W'(1);
            end

            r_cap_v <= i_cmd.img_rd;
            r_arg_v <= i_cmd.arg_rd;

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                if (read_is_last) begin
                    r_read_cnt <= '0;
                    r_load_cnt <= '0;
                end else begin
                    r_read_cnt <= r_read_cnt + CNT_W'(1);
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.latch) begin
                r_read_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_sel <= i_cmd.nb;
        r_arg_idx <= r_k[HW-1:0];

        if (i_cmd.latch) begin
            r_lw    <= w_cl;
            r_lh    <= h_cl;
            r_total <= total_cfg;
            r_dith  <= r_cfg_dith;
            r_auto  <= r_cfg_auto;
            r_scfg  <= r_cfg_shadow;
        end

        if (r_cap_v) begin
            case (r_cap_sel)
                ipss_pkg::NB_C:  r_vc  <= img_rdata;
                ipss_pkg::NB_L1: r_vl1 <= img_rdata;
                ipss_pkg::NB_L2: r_vl2 <= img_rdata;
                ipss_pkg::NB_R1: r_vr1 <= img_rdata;
                ipss_pkg::NB_R2: r_vr2 <= img_rdata;
                ipss_pkg::NB_U1: r_vu1 <= img_rdata;
                ipss_pkg::NB_U2: r_vu2 <= img_rdata;
                ipss_pkg::NB_D1: r_vd1 <= img_rdata;
                ipss_pkg::NB_D2: r_vd2 <= img_rdata;
                ipss_pkg::NB_X:  r_x   <= img_rdata;
                default: ;
            endcase
        end

        if (i_cmd.k_clr) begin
            r_k        <= '0;
            r_best     <= '0;
            r_best_cnt <= '0;
        end else begin
            if (i_cmd.sweep_clr || i_cmd.arg_rd) begin
                r_k <= r_k + SWP_W'(1);
            end
            if (r_arg_v && hst_rdata > r_best_cnt) begin
                r_best     <= r_arg_idx;
                r_best_cnt <= hst_rdata;
            end
        end

        if (i_cmd.pick) begin
            r_s     <= r_auto ? r_best : r_scfg;
            r_clash <= (r_auto ? r_best : r_scfg) == r_x;
        end

        if (i_cmd.pos_clr) begin
            r_i <= '0;
            r_j <= '0;
            r_p <= '0;
        end else if (i_cmd.adv) begin
            if (wrap) begin
                r_i <= '0;
                r_j <= r_j + ROW_W'(1);
                r_p <= r_p - CNT_W'(r_i) + CNT_W'(r_lw);
            end else begin
                r_i <= DIM_W'(i_next);
                r_p <= r_p + (i_cmd.skip ? CNT_W'(2) : CNT_W'(1));
            end
        end

        if (i_cmd.out_load) begin
            r_out_pixel  <= img_rdata;
            r_out_shadow <= msk_rdata;
            r_out_last   <= read_is_last;
            r_out_clash  <= r_clash;
            r_out_used   <= r_s;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_pixel_out         = r_out_pixel;
    assign o_is_shadow         = r_out_shadow;
    assign o_last              = r_out_last;
    assign o_index_clash       = r_out_clash;
    assign o_shadow_index_used = r_out_used;

endmodule

[sv/ipss_ctrl.sv]
module ipss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_mode,
    output logic           o_ready,
    input  ipss_pkg::t_sts i_sts,
    output ipss_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_GETX,
        S_CLR,
        S_RD,
        S_CAP,
        S_ACT,
        S_HINC,
        S_ACT2,
        S_ADV,
        S_ARG,
        S_ARGL,
        S_PICK,
        S_PCHK,
        S_READ,
        S_FETCH
    } t_state;

    t_state        r_state, n_state;
    ipss_pkg::t_nb r_nb, n_nb;
    logic          r_hist, n_hist;
    logic          accept;

    assign o_ready = (r_state == S_LOAD || r_state == S_READ) && i_sts.out_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state   = r_state;
        n_nb      = r_nb;
        n_hist    = r_hist;
        o_cmd     = '0;
        o_cmd.nb  = r_nb;
        case (r_state)
            S_LOAD: begin
                if (accept && i_mode == ipss_pkg::MODE_LOAD) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_sts.load_done) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_GETX;
                    end
                end
            end
            S_GETX: begin
                o_cmd.img_rd = 1'b1;
                o_cmd.nb     = ipss_pkg::NB_X;
                o_cmd.k_clr  = 1'b1;
                n_state      = S_CLR;
            end
            S_CLR: begin
                o_cmd.sweep_clr = 1'b1;
                if (i_sts.sweep_done) begin
                    n_nb = ipss_pkg::NB_C;
                    if (i_sts.auto_on) begin
                        o_cmd.pos_clr = 1'b1;
                        n_hist        = 1'b1;
                        n_state       = S_RD;
                    end else begin
                        n_state = S_PICK;
                    end
                end
            end
            S_RD: begin
                o_cmd.img_rd = 1'b1;
                if (r_nb == ipss_pkg::NB_D2) begin
                    n_state = S_CAP;
                end else begin
                    n_nb = ipss_pkg::t_nb'(4'(r_nb) + 4'd1);
                end
            end
            S_CAP: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                n_state = S_ADV;
                if (r_hist) begin
                    if (i_sts.hist_hit) begin
                        n_state = S_HINC;
                    end
                end else if (i_sts.shadow_hit) begin
                    o_cmd.sep_wr = 1'b1;
                    if (i_sts.dith) begin
                        n_state = S_ACT2;
                    end
                end else if (i_sts.dmark) begin
                    o_cmd.dmask_wr = 1'b1;
                end
            end
            S_HINC: begin
                o_cmd.hist_inc = 1'b1;
                n_state        = S_ADV;
            end
            S_ACT2: begin
                o_cmd.next_wr = i_sts.right_mark;
                o_cmd.adv     = 1'b1;
                o_cmd.skip    = 1'b1;
                n_nb          = ipss_pkg::NB_C;
                n_state       = i_sts.last2 ? S_READ : S_RD;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_nb      = ipss_pkg::NB_C;
                if (!i_sts.last1) begin
                    n_state = S_RD;
                end else if (r_hist) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_ARG;
                end else begin
                    n_state = S_READ;
                end
            end
            S_ARG: begin
                o_cmd.arg_rd = 1'b1;
                if (i_sts.arg_done) begin
                    n_state = S_ARGL;
                end
            end
            S_ARGL: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_PCHK;
            end
            S_PCHK: begin
                if (i_sts.clash) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.pos_clr = 1'b1;
                    n_hist        = 1'b0;
                    n_nb          = ipss_pkg::NB_C;
                    n_state       = S_RD;
                end
            end
            S_READ: begin
                if (accept && i_mode == ipss_pkg::MODE_FETCH) begin
                    o_cmd.fetch_rd = 1'b1;
                    n_state        = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.out_load = 1'b1;
                n_state        = i_sts.last_read ? S_LOAD : S_READ;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_nb    <= ipss_pkg::NB_C;
            r_hist  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nb    <= n_nb;
            r_hist  <= n_hist;
        end
    end

endmodule

[sv/isolated_pixel_shadow_separator.sv]
// Channel   | Handshake           | Payload
// ----------+---------------------+-------------------------------------------------
// input     | i_valid / o_ready   | i_mode, i_pixel_in
// output    | o_valid / i_ready   | o_pixel_out, o_is_shadow, o_last, o_index_clash,
//           |                     | o_shadow_index_used
// config    | i_cfg_we            | i_cfg_index, i_cfg_data
//
// A load transaction writes one pixel; the last one of an image starts processing.
// Processing: a mask/histogram clear sweep and a shadow pick, then each pixel in turn
// for each pass, its neighbors read one by one through the single image memory
// read port (a histogram hit adds a state; a dithered shadow also covers its right
// neighbor); auto mode adds one histogram pass and a search. A fetch transaction
// moves one pixel into the output register. Reset is synchronous, active low. A
// stalled output holds its register and blocks the next input transaction.
module isolated_pixel_shadow_separator #(
    parameter int MAX_WIDTH  = ipss_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ipss_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic [ipss_pkg::COLOR_W-1:0]     i_pixel_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ipss_pkg::COLOR_W-1:0]     o_pixel_out,
    output logic                             o_is_shadow,
    output logic                             o_last,
    output logic                             o_index_clash,
    output logic [ipss_pkg::COLOR_W-1:0]     o_shadow_index_used,
    input  logic                             i_cfg_we,
    input  logic [ipss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ipss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ipss_pkg::t_cmd cmd;
    ipss_pkg::t_sts sts;

    ipss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ipss_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_pixel_in          (i_pixel_in),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_pixel_out         (o_pixel_out),
        .o_is_shadow         (o_is_shadow),
        .o_last              (o_last),
        .o_index_clash       (o_index_clash),
        .o_shadow_index_used (o_shadow_index_used)
    );

endmodule
